/* hw/rtl/llc_pkg.sv */
// ----------------------------------------------------------------------------
// llc_pkg
// Shared widths, constants, types and the CORDIC arctangent table for the
// latitude/longitude to Cartesian converter.
// ----------------------------------------------------------------------------
package llc_pkg;

  localparam int CORDIC_ITERATIONS = 24;

  localparam int LAT_W  = 24;
  localparam int LON_W  = 26;
  localparam int HGT_W  = 32;
  localparam int RAD_W  = 32;
  localparam int OUT_W  = 40;

  localparam int ANG_W  = 27;   // wrapped angle, Q16 degrees
  localparam int MAG_W  = 23;   // folded angle magnitude
  localparam int CW     = 34;   // CORDIC datapath, Q30
  localparam int RT_W   = 34;   // radius plus height
  localparam int STEP_W = 5;
  localparam int FRAC_Q = 30;

  localparam int ANGLE_STAGES = 5;
  localparam int SCALE_STAGES = 5;
  localparam int PIPE_DEPTH   = ANGLE_STAGES + CORDIC_ITERATIONS + SCALE_STAGES;
  localparam int CNT_W        = $clog2(PIPE_DEPTH + 1);

  localparam logic [RAD_W-1:0] RADIUS_RESET = 32'd1631034624;

  localparam logic signed [ANG_W-1:0] ANG_FULL    = 27'sd23592960;
  localparam logic signed [ANG_W-1:0] ANG_HALF    = 27'sd11796480;
  localparam logic signed [ANG_W-1:0] ANG_QUARTER = 27'sd5898240;

  // degrees (Q16) to radians (Q30): 285*m + (m*5631313 + 2949120) / (45 * 2^17)
  localparam logic [22:0] RAD_FRAC_MUL   = 23'd5631313;
  localparam logic [21:0] RAD_FRAC_BIAS  = 22'd2949120;
  localparam logic [8:0]  RAD_INT_MUL    = 9'd285;
  localparam int          RAD_FRAC_SHIFT = 17;
  localparam logic [28:0] DIV45_RECIP    = 29'd381774871;
  localparam int          DIV45_SHIFT    = 34;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } llc_rot_t;

  typedef struct packed {
    llc_rot_t                lat;
    llc_rot_t                lon;
    logic                    lat_neg;
    logic                    lon_neg;
    logic signed [RT_W-1:0]  radius;
  } llc_cell_t;

  function automatic logic [31:0] atan_q30(input logic [STEP_W-1:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:  a = 32'h3243F6A8;
      5'd1:  a = 32'h1DAC6705;
      5'd2:  a = 32'h0FADBAFC;
      5'd3:  a = 32'h07F56EA6;
      5'd4:  a = 32'h03FEAB76;
      5'd5:  a = 32'h01FFD55B;
      5'd6:  a = 32'h00FFFAAA;
      5'd7:  a = 32'h007FFF55;
      5'd8:  a = 32'h003FFFEA;
      5'd9:  a = 32'h001FFFFD;
      5'd10: a = 32'h000FFFFF;
      5'd11: a = 32'h0007FFFF;
      5'd12: a = 32'h0003FFFF;
      5'd13: a = 32'h0001FFFF;
      5'd14: a = 32'h0000FFFF;
      5'd15: a = 32'h00007FFF;
      5'd16: a = 32'h00003FFF;
      5'd17: a = 32'h00001FFF;
      5'd18: a = 32'h00000FFF;
      5'd19: a = 32'h000007FF;
      5'd20: a = 32'h000003FF;
      5'd21: a = 32'h000001FF;
      5'd22: a = 32'h000000FF;
      5'd23: a = 32'h0000007F;
      5'd24: a = 32'h0000003F;
      5'd25: a = 32'h0000001F;
      5'd26: a = 32'h0000000F;
      5'd27: a = 32'h00000008;
      5'd28: a = 32'h00000004;
      5'd29: a = 32'h00000002;
      5'd30: a = 32'h00000001;
      5'd31: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

/* hw/rtl/llc_angle.sv */
// ----------------------------------------------------------------------------
// llc_angle
// Wraps and folds both angles, converts them to Q30 radians and seeds the
// CORDIC cells. Five register stages with a local ready chain.
// ----------------------------------------------------------------------------
module llc_angle (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [llc_pkg::LAT_W-1:0]  latitude,
  input  logic signed [llc_pkg::LON_W-1:0]  longitude,
  input  logic signed [llc_pkg::HGT_W-1:0]  height,
  input  logic        [llc_pkg::RAD_W-1:0]  radius,
  output logic                              out_valid,
  input  logic                              out_ready,
  output llc_pkg::llc_cell_t                out_data
);
  import llc_pkg::*;

  localparam int NS   = ANGLE_STAGES;
  localparam int P_W  = 46;
  localparam int Q_W  = P_W - RAD_FRAC_SHIFT;
  localparam int QP_W = Q_W + 29;
  localparam int I_W  = 32;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;
  logic [NS-1:0] vin;
  logic [NS-1:0] ld;

  assign vin     = {vld[NS-2:0], in_valid};
  assign rdy[NS] = out_ready;
  assign ld      = rdy[NS-1:0] & vin;

  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vin[k];
        end
      end
    end
  end

  // stage registers
  logic signed [ANG_W-1:0] s0_ang [2];
  logic signed [RT_W-1:0]  s0_rt;
  logic [MAG_W-1:0]        s1_mag [2];
  logic [1:0]              s1_sgn, s1_neg;
  logic signed [RT_W-1:0]  s1_rt;
  logic [P_W-1:0]          s2_p [2];
  logic [I_W-1:0]          s2_i [2];
  logic [1:0]              s2_sgn, s2_neg;
  logic signed [RT_W-1:0]  s2_rt;
  logic [MAG_W-1:0]        s3_d [2];
  logic [I_W-1:0]          s3_i [2];
  logic [1:0]              s3_sgn, s3_neg;
  logic signed [RT_W-1:0]  s3_rt;

  logic signed [ANG_W-1:0] ang_in [2];
  logic signed [ANG_W-1:0] wrp [2];
  logic signed [ANG_W-1:0] fld [2];
  logic [1:0]              fneg;
  logic [MAG_W-1:0]        mag [2];
  logic [Q_W-1:0]          quo [2];
  logic [QP_W-1:0]         qprod [2];
  logic signed [CW-1:0]    zmag [2];
  logic signed [CW-1:0]    zval [2];

  assign ang_in[0] = {{(ANG_W-LAT_W){latitude[LAT_W-1]}}, latitude};
  assign ang_in[1] = {{(ANG_W-LON_W){longitude[LON_W-1]}}, longitude};

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      // into [-180, 180)
      priority if (ang_in[k] >= ANG_HALF) begin
        wrp[k] = ang_in[k] - ANG_FULL;
      end else if (ang_in[k] < -ANG_HALF) begin
        wrp[k] = ang_in[k] + ANG_FULL;
      end else begin
        wrp[k] = ang_in[k];
      end
      // into [-90, 90], sine and cosine flipped
      priority if (s0_ang[k] > ANG_QUARTER) begin
        fld[k]  = s0_ang[k] - ANG_HALF;
        fneg[k] = 1'b1;
      end else if (s0_ang[k] < -ANG_QUARTER) begin
        fld[k]  = s0_ang[k] + ANG_HALF;
        fneg[k] = 1'b1;
      end else begin
        fld[k]  = s0_ang[k];
        fneg[k] = 1'b0;
      end
      mag[k]   = MAG_W'(fld[k][ANG_W-1] ? -fld[k] : fld[k]);
      quo[k]   = s2_p[k][P_W-1:RAD_FRAC_SHIFT];
      qprod[k] = QP_W'(quo[k]) * QP_W'(DIV45_RECIP);
      zmag[k]  = CW'(s3_i[k]) + CW'(s3_d[k]);
      zval[k]  = s3_sgn[k] ? -zmag[k] : zmag[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s0_ang <= wrp;
      s0_rt  <= $signed({2'b00, radius}) + {{(RT_W-HGT_W){height[HGT_W-1]}}, height};
    end
    if (ld[1]) begin
      for (int k = 0; k < 2; k++) begin
        s1_mag[k] <= mag[k];
        s1_sgn[k] <= fld[k][ANG_W-1];
      end
      s1_neg <= fneg;
      s1_rt  <= s0_rt;
    end
    if (ld[2]) begin
      for (int k = 0; k < 2; k++) begin
        s2_p[k] <= P_W'(s1_mag[k]) * P_W'(RAD_FRAC_MUL) + P_W'(RAD_FRAC_BIAS);
        s2_i[k] <= I_W'(s1_mag[k]) * I_W'(RAD_INT_MUL);
      end
      s2_sgn <= s1_sgn;
      s2_neg <= s1_neg;
      s2_rt  <= s1_rt;
    end
    if (ld[3]) begin
      for (int k = 0; k < 2; k++) begin
        s3_d[k] <= qprod[k][DIV45_SHIFT+MAG_W-1:DIV45_SHIFT];
        s3_i[k] <= s2_i[k];
      end
      s3_sgn <= s2_sgn;
      s3_neg <= s2_neg;
      s3_rt  <= s2_rt;
    end
    if (ld[4]) begin
      out_data.lat.x   <= CORDIC_GAIN;
      out_data.lat.y   <= '0;
      out_data.lat.z   <= zval[0];
      out_data.lon.x   <= CORDIC_GAIN;
      out_data.lon.y   <= '0;
      out_data.lon.z   <= zval[1];
      out_data.lat_neg <= s3_neg[0];
      out_data.lon_neg <= s3_neg[1];
      out_data.radius  <= s3_rt;
    end
  end

endmodule

/* hw/rtl/llc_cordic_cell.sv */
// ----------------------------------------------------------------------------
// llc_cordic_cell
// One rotation-mode CORDIC step for latitude and longitude side by side,
// with one register stage and its own ready.
// ----------------------------------------------------------------------------
module llc_cordic_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [llc_pkg::STEP_W-1:0]   step,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  llc_pkg::llc_cell_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output llc_pkg::llc_cell_t           out_data
);
  import llc_pkg::*;

  llc_cell_t out_data_next;

  function automatic llc_rot_t rotate(input llc_rot_t r, input logic [STEP_W-1:0] s);
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] da;
    llc_rot_t             o;
    dx = r.y >>> s;
    dy = r.x >>> s;
    da = CW'(atan_q30(s));
    if (!r.z[CW-1]) begin
      o.x = r.x - dx;
      o.y = r.y + dy;
      o.z = r.z - da;
    end else begin
      o.x = r.x + dx;
      o.y = r.y - dy;
      o.z = r.z + da;
    end
    return o;
  endfunction

  always_comb begin
    out_data_next     = in_data;
    out_data_next.lat = rotate(in_data.lat, step);
    out_data_next.lon = rotate(in_data.lon, step);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= out_data_next;
    end
  end

endmodule

/* hw/rtl/llc_scale.sv */
// ----------------------------------------------------------------------------
// llc_scale
// Applies the fold sign, scales by radius plus height and rounds to the
// 40-bit outputs. Products are split in two partials; five register stages.
// ----------------------------------------------------------------------------
module llc_scale (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  llc_pkg::llc_cell_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [llc_pkg::OUT_W-1:0]  x_coord,
  output logic signed [llc_pkg::OUT_W-1:0]  y_coord,
  output logic signed [llc_pkg::OUT_W-1:0]  z_coord
);
  import llc_pkg::*;

  localparam int NS    = SCALE_STAGES;
  localparam int L1    = 17;
  localparam int PL1_W = L1 + 1 + CW;
  localparam int PH1_W = RT_W - L1 + CW;
  localparam int PA_W  = RT_W + CW;
  localparam int T_W   = 36;
  localparam int L2    = 18;
  localparam int PL2_W = L2 + 1 + CW;
  localparam int PH2_W = T_W - L2 + CW;
  localparam int PB_W  = T_W + CW;
  localparam int R_W   = 48;

  localparam logic signed [PA_W-1:0]  RND_A = PA_W'(1) << (FRAC_Q - 1);
  localparam logic signed [PB_W-1:0]  RND_B = PB_W'(1) << (FRAC_Q - 1);
  localparam logic signed [R_W-1:0]   SAT_HI = {{(R_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [R_W-1:0]   SAT_LO = -SAT_HI - R_W'(1);

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [R_W-1:0] v);
    logic signed [OUT_W-1:0] o;
    priority if (v > SAT_HI) begin
      o = SAT_HI[OUT_W-1:0];
    end else if (v < SAT_LO) begin
      o = SAT_LO[OUT_W-1:0];
    end else begin
      o = v[OUT_W-1:0];
    end
    return o;
  endfunction

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;
  logic [NS-1:0] vin;
  logic [NS-1:0] ld;

  assign vin     = {vld[NS-2:0], in_valid};
  assign rdy[NS] = out_ready;
  assign ld      = rdy[NS-1:0] & vin;

  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vin[k];
        end
      end
    end
  end

  logic signed [CW-1:0]    m0_clat, m0_slat, m0_clon, m0_slon;
  logic signed [RT_W-1:0]  m0_rt;
  logic signed [PL1_W-1:0] m1_clat_lo, m1_slat_lo;
  logic signed [PH1_W-1:0] m1_clat_hi, m1_slat_hi;
  logic signed [CW-1:0]    m1_clon, m1_slon;
  logic signed [T_W-1:0]   m2_t;
  logic signed [R_W-1:0]   m2_z;
  logic signed [CW-1:0]    m2_clon, m2_slon;
  logic signed [PL2_W-1:0] m3_x_lo, m3_y_lo;
  logic signed [PH2_W-1:0] m3_x_hi, m3_y_hi;
  logic signed [OUT_W-1:0] m3_z;

  logic signed [PA_W-1:0]  sum_c, sum_s, rnd_c, rnd_s;
  logic signed [PB_W-1:0]  sum_x, sum_y, rnd_x, rnd_y;

  always_comb begin
    sum_c = (PA_W'(m1_clat_hi) <<< L1) + PA_W'(m1_clat_lo) + RND_A;
    sum_s = (PA_W'(m1_slat_hi) <<< L1) + PA_W'(m1_slat_lo) + RND_A;
    rnd_c = sum_c >>> FRAC_Q;
    rnd_s = sum_s >>> FRAC_Q;
    sum_x = (PB_W'(m3_x_hi) <<< L2) + PB_W'(m3_x_lo) + RND_B;
    sum_y = (PB_W'(m3_y_hi) <<< L2) + PB_W'(m3_y_lo) + RND_B;
    rnd_x = sum_x >>> FRAC_Q;
    rnd_y = sum_y >>> FRAC_Q;
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      m0_clat <= in_data.lat_neg ? -in_data.lat.x : in_data.lat.x;
      m0_slat <= in_data.lat_neg ? -in_data.lat.y : in_data.lat.y;
      m0_clon <= in_data.lon_neg ? -in_data.lon.x : in_data.lon.x;
      m0_slon <= in_data.lon_neg ? -in_data.lon.y : in_data.lon.y;
      m0_rt   <= in_data.radius;
    end
    if (ld[1]) begin
      m1_clat_lo <= $signed({1'b0, m0_rt[L1-1:0]}) * m0_clat;
      m1_clat_hi <= $signed(m0_rt[RT_W-1:L1]) * m0_clat;
      m1_slat_lo <= $signed({1'b0, m0_rt[L1-1:0]}) * m0_slat;
      m1_slat_hi <= $signed(m0_rt[RT_W-1:L1]) * m0_slat;
      m1_clon    <= m0_clon;
      m1_slon    <= m0_slon;
    end
    if (ld[2]) begin
      m2_t    <= rnd_c[T_W-1:0];
      m2_z    <= rnd_s[R_W-1:0];
      m2_clon <= m1_clon;
      m2_slon <= m1_slon;
    end
    if (ld[3]) begin
      m3_x_lo <= $signed({1'b0, m2_t[L2-1:0]}) * m2_clon;
      m3_x_hi <= $signed(m2_t[T_W-1:L2]) * m2_clon;
      m3_y_lo <= $signed({1'b0, m2_t[L2-1:0]}) * m2_slon;
      m3_y_hi <= $signed(m2_t[T_W-1:L2]) * m2_slon;
      m3_z    <= sat_out(m2_z);
    end
    if (ld[4]) begin
      x_coord <= sat_out(rnd_x[R_W-1:0]);
      y_coord <= sat_out(rnd_y[R_W-1:0]);
      z_coord <= m3_z;
    end
  end

endmodule

/* hw/rtl/latlon_to_cartesian.sv */
// ----------------------------------------------------------------------------
// latlon_to_cartesian
// Spherical latitude/longitude/height to Cartesian X, Y, Z converter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one request: latitude and
//   longitude in Q16 degrees, height in Q8 metres. Output channel
//   (out_valid/out_ready) returns x_coord, y_coord, z_coord in Q8 metres.
//   cfg_we/cfg_wdata write the sphere radius (Q8 metres); write only while
//   no request is in flight.
//   The pipeline has five angle stages, one CORDIC cell per iteration and five
//   scaling stages. A new request is taken every cycle unless every stage
//   holds a request and the receiver stalls.
//   Every stage has its own valid bit and holds when the next is full, so
//   bubbles close up; in_ready drops only once every stage holds a request
//   and the receiver stalls. Results stay on the outputs until taken.
//   Reset empties the pipeline and sets the radius back to 6371229 m.
// ----------------------------------------------------------------------------
module latlon_to_cartesian (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [llc_pkg::LAT_W-1:0]  latitude,
  input  logic signed [llc_pkg::LON_W-1:0]  longitude,
  input  logic signed [llc_pkg::HGT_W-1:0]  height,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [llc_pkg::OUT_W-1:0]  x_coord,
  output logic signed [llc_pkg::OUT_W-1:0]  y_coord,
  output logic signed [llc_pkg::OUT_W-1:0]  z_coord,
  input  logic                              cfg_we,
  input  logic        [llc_pkg::RAD_W-1:0]  cfg_wdata
);
  import llc_pkg::*;

  localparam int N = CORDIC_ITERATIONS;

  logic [RAD_W-1:0] sphere_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= RADIUS_RESET;
    end else if (cfg_we) begin
      sphere_radius <= cfg_wdata;
    end
  end

  logic      cv [N+1];
  logic      cr [N+1];
  llc_cell_t cd [N+1];

  llc_angle u_angle (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .latitude  (latitude),
    .longitude (longitude),
    .height    (height),
    .radius    (sphere_radius),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out_data  (cd[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_cell
    llc_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .step      (STEP_W'(g)),
      .in_valid  (cv[g]),
      .in_ready  (cr[g]),
      .in_data   (cd[g]),
      .out_valid (cv[g+1]),
      .out_ready (cr[g+1]),
      .out_data  (cd[g+1])
    );
  end

  llc_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cv[N]),
    .in_ready  (cr[N]),
    .in_data   (cd[N]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .z_coord   (z_coord)
  );

  // requests held between the two channels
  logic [CNT_W-1:0] inflight;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CNT_W'(in_valid && in_ready) - CNT_W'(out_valid && out_ready);
    end
  end

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != '0)
    else $error("result offered with no request in flight");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= CNT_W'(PIPE_DEPTH))
    else $error("more requests in flight than pipeline stages");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> inflight == CNT_W'(PIPE_DEPTH))
    else $error("input stalled while pipeline has room");

endmodule

/* bench/llc_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// llc_checker
// Watches both channels and the radius port of the lat/lon to Cartesian
// converter. Each accepted request is turned into expected X, Y, Z by an
// independent CORDIC model and queued. Each accepted result is compared
// field by field with the oldest entry in that queue.
// ----------------------------------------------------------------------------
module llc_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [llc_pkg::LAT_W-1:0]  latitude,
  input  logic signed [llc_pkg::LON_W-1:0]  longitude,
  input  logic signed [llc_pkg::HGT_W-1:0]  height,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [llc_pkg::OUT_W-1:0]  x_coord,
  input  logic signed [llc_pkg::OUT_W-1:0]  y_coord,
  input  logic signed [llc_pkg::OUT_W-1:0]  z_coord,
  input  logic                              cfg_we,
  input  logic        [llc_pkg::RAD_W-1:0]  cfg_wdata,
  output int                                fail_count,
  output int                                outstanding,
  output int                                checked_count
);
  import llc_pkg::*;

  localparam longint FULL_TURN    = 23592960;
  localparam longint HALF_TURN    = 11796480;
  localparam longint QUARTER_TURN = 5898240;
  localparam longint PI_Q32       = 64'sd13493037704;
  localparam longint DEG_DIV      = 47185920;
  localparam longint GAIN_Q30     = 652032874;
  localparam longint HALF_Q30     = 536870912;
  localparam longint OUT_HI       = 64'sd549755813887;
  localparam longint OUT_LO       = -64'sd549755813888;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } coord_t;

  typedef struct packed {
    longint sn;
    longint cs;
  } trig_t;

  longint           atan_step [0:31];
  logic [RAD_W-1:0] radius;
  coord_t           expected_coords [$];
  int               errors;

  assign fail_count = errors;

  initial begin
    errors = 0;
    atan_step = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
      64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
      64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
      64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008,
      64'h00000004, 64'h00000002, 64'h00000001, 64'h00000000
    };
  end

  task automatic report(input string msg);
    errors++;
    $display("%0t: %s", $time, msg);
  endtask

  // angle in Q16 degrees to sine and cosine in Q30
  function automatic trig_t angle_trig(input longint deg_q16);
    longint r;
    longint m;
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    logic   flip;
    int     i;
    trig_t  res;
    r = deg_q16 % FULL_TURN;
    flip = 1'b0;
    if (r >= HALF_TURN) r = r - FULL_TURN;
    if (r < -HALF_TURN) r = r + FULL_TURN;
    if (r > QUARTER_TURN) begin
      r = r - HALF_TURN;
      flip = 1'b1;
    end else if (r < -QUARTER_TURN) begin
      r = r + HALF_TURN;
      flip = 1'b1;
    end
    m = (r < 0) ? -r : r;
    z = (m * PI_Q32 + DEG_DIV / 2) / DEG_DIV;
    if (r < 0) z = -z;
    x = GAIN_Q30;
    y = 0;
    for (i = 0; i < CORDIC_ITERATIONS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_step[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_step[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    res.sn = y;
    res.cs = x;
    return res;
  endfunction

  function automatic longint round_q30(input longint p);
    return (p + HALF_Q30) >>> 30;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_out(input longint v);
    if (v > OUT_HI) v = OUT_HI;
    if (v < OUT_LO) v = OUT_LO;
    return v[OUT_W-1:0];
  endfunction

  function automatic coord_t project_point(input logic signed [LAT_W-1:0] lat,
                                           input logic signed [LON_W-1:0] lon,
                                           input logic signed [HGT_W-1:0] hgt,
                                           input logic [RAD_W-1:0] rad);
    longint rt;
    longint t;
    trig_t  tl;
    trig_t  tn;
    coord_t res;
    rt = longint'(rad) + longint'(hgt);
    tl = angle_trig(longint'(lat));
    tn = angle_trig(longint'(lon));
    t = round_q30(rt * tl.cs);
    res.x = clamp_out(round_q30(t * tn.cs));
    res.y = clamp_out(round_q30(t * tn.sn));
    res.z = clamp_out(round_q30(rt * tl.sn));
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    coord_t want;
    if (rst) begin
      radius = RADIUS_RESET;
      expected_coords.delete();
      outstanding <= 0;
      checked_count <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_coords.push_back(project_point(latitude, longitude, height, radius));
      end
      if (out_valid && out_ready) begin
        if (expected_coords.size() == 0) begin
          report($sformatf("result with no request pending: x %0d y %0d z %0d",
                           x_coord, y_coord, z_coord));
        end else begin
          want = expected_coords.pop_front();
          if (x_coord !== want.x)
            report($sformatf("x_coord %0d, expected %0d", x_coord, want.x));
          if (y_coord !== want.y)
            report($sformatf("y_coord %0d, expected %0d", y_coord, want.y));
          if (z_coord !== want.z)
            report($sformatf("z_coord %0d, expected %0d", z_coord, want.z));
          checked_count <= checked_count + 1;
        end
      end
      if (cfg_we) radius = cfg_wdata;
      outstanding <= expected_coords.size();
    end
  end

endmodule

/* bench/tb_latlon_to_cartesian.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_latlon_to_cartesian
// Drives the lat/lon to Cartesian converter with directed corner points and
// random points under several sphere radii and stall mixes on both
// channels; the checker beside the block predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_latlon_to_cartesian;
  import llc_pkg::*;

  localparam int RANDOM_POINTS = 1400;
  localparam int SEGMENTS      = 6;
  localparam int DRAIN_CYCLES  = PIPE_DEPTH + 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DEG           = 65536;
  localparam int QUARTER       = 90 * DEG;
  localparam int HALF          = 180 * DEG;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [LAT_W-1:0] latitude = '0;
  logic signed [LON_W-1:0] longitude = '0;
  logic signed [HGT_W-1:0] height = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [OUT_W-1:0] x_coord;
  logic signed [OUT_W-1:0] y_coord;
  logic signed [OUT_W-1:0] z_coord;
  logic                    cfg_we = 1'b0;
  logic [RAD_W-1:0]        cfg_wdata = '0;

  int               fail_count;
  int               outstanding;
  int               checked_count;
  int               tx_idle_pct = 0;
  int               rx_idle_pct = 0;
  int               points_sent = 0;
  int               cycles = 0;
  logic [RAD_W-1:0] radius_now = RADIUS_RESET;

  latlon_to_cartesian dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .latitude  (latitude),
    .longitude (longitude),
    .height    (height),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .z_coord   (z_coord),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  llc_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .latitude      (latitude),
    .longitude     (longitude),
    .height        (height),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .x_coord       (x_coord),
    .y_coord       (y_coord),
    .z_coord       (z_coord),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests still pending", cycles, outstanding);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_point(input int lat, input int lon, input int hgt);
    if (tx_idle_pct > 0) begin
      while ($urandom_range(99) < tx_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    latitude  <= LAT_W'(lat);
    longitude <= LON_W'(lon);
    height    <= hgt;
    do @(posedge clk); while (!in_ready);
    points_sent++;
  endtask

  task automatic send_random();
    int                      pick;
    int                      lat;
    int                      lon;
    logic signed [HGT_W-1:0] hgt;
    longint                  under;
    pick = $urandom_range(99);
    lat  = int'($urandom_range(2 * QUARTER)) - QUARTER;
    lon  = int'($urandom_range(3 * HALF)) - HALF;
    hgt  = int'($urandom_range(1 << 24)) - (1 << 23);
    if (pick < 15) begin
      lat = $urandom();
      lon = $urandom();
      hgt = $urandom();
    end else if (pick < 28) begin
      // near the quadrant and half-turn boundaries
      lat = (int'($urandom_range(2)) - 1) * QUARTER + int'($urandom_range(4)) - 2;
      lon = (int'($urandom_range(6)) - 2) * QUARTER + int'($urandom_range(4)) - 2;
    end else if (pick < 36) begin
      hgt = $urandom();
    end else if (pick < 42) begin
      // total radius at or below zero, unless the height saturates at its minimum
      under = -longint'(radius_now) - longint'($urandom_range(1 << 16));
      if (under < -64'sd2147483648) under = -64'sd2147483648;
      hgt = under[HGT_W-1:0];
    end
    send_point(lat, lon, hgt);
  endtask

  task automatic write_radius(input logic [RAD_W-1:0] value);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    radius_now = value;
  endtask

  initial begin
    logic [RAD_W-1:0] radius_set [SEGMENTS];
    int               directed;
    radius_set[0] = '1;
    radius_set[1] = '0;
    radius_set[2] = $urandom();
    radius_set[3] = RADIUS_RESET;
    radius_set[4] = $urandom_range(65535, 1);
    radius_set[5] = $urandom();

    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 14;
    rx_idle_pct = 47;

    // corner points under the reset radius
    send_point(0, 0, 0);
    send_point(QUARTER, 0, 0);
    send_point(-QUARTER, 0, 0);
    send_point(0, HALF, 0);
    send_point(0, -HALF, 0);
    send_point(0, 2 * HALF, 0);
    send_point(0, QUARTER, 0);
    send_point(0, -QUARTER, 0);
    send_point(0, 3 * QUARTER, 0);
    send_point(45 * DEG, 45 * DEG, 0);
    send_point(8388607, 33554431, 0);
    send_point(-8388608, -33554432, 0);
    send_point(QUARTER + 1, HALF - 1, 256);
    send_point(-QUARTER - 1, -HALF - 1, -256);
    send_point(30 * DEG, 60 * DEG, 32'sh7FFFFFFF);
    send_point(-30 * DEG, -120 * DEG, 32'sh80000000);
    send_point(10 * DEG, 20 * DEG, -int'(RADIUS_RESET));
    send_point(-10 * DEG, 200 * DEG, -int'(RADIUS_RESET) - 1);
    send_point(1, -1, 1);
    send_point(60 * DEG, 300 * DEG, 12345678);
    send_point(QUARTER, 2 * HALF, -1);
    send_point(-QUARTER, -HALF + 1, 32'sh55555555);
    directed = points_sent;

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 2) begin
        tx_idle_pct = 47;
        rx_idle_pct = 14;
      end else if (seg == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_radius(radius_set[seg]);
      repeat (RANDOM_POINTS / SEGMENTS) send_random();
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d points sent (%0d corner points), %0d results checked, %0d mismatches",
             points_sent, directed, checked_count, fail_count);
    $display("radii: reset value, zero, all ones and random; stalls on both sides and none");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
